FILE: rtl/acrp_pkg.sv
package acrp_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned LenW   = 16;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_VER      = 4'd0;
  localparam logic [PhaseW-1:0] PH_PROF     = 4'd1;
  localparam logic [PhaseW-1:0] PH_COMPAT   = 4'd2;
  localparam logic [PhaseW-1:0] PH_LEVEL    = 4'd3;
  localparam logic [PhaseW-1:0] PH_LENSIZE  = 4'd4;
  localparam logic [PhaseW-1:0] PH_SPS_CNT  = 4'd5;
  localparam logic [PhaseW-1:0] PH_SPS_LH   = 4'd6;
  localparam logic [PhaseW-1:0] PH_SPS_LL   = 4'd7;
  localparam logic [PhaseW-1:0] PH_SPS_DATA = 4'd8;
  localparam logic [PhaseW-1:0] PH_PPS_CNT  = 4'd9;
  localparam logic [PhaseW-1:0] PH_PPS_LH   = 4'd10;
  localparam logic [PhaseW-1:0] PH_PPS_LL   = 4'd11;
  localparam logic [PhaseW-1:0] PH_PPS_DATA = 4'd12;
  localparam logic [PhaseW-1:0] PH_IGNORE   = 4'd13;

  localparam logic [7:0] CFG_REC_VERSION = 8'd1;
  localparam logic [7:0] LEN_SIZE_MASK   = 8'h03;
  localparam logic [7:0] SPS_CNT_MASK    = 8'h1f;
  localparam logic [7:0] PS_COUNT_ONE    = 8'd1;

  localparam logic [LenW-1:0] MAX_SPS_RESET = 16'd256;
  localparam logic [LenW-1:0] MAX_PPS_RESET = 16'd64;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_SPS = 1'b0;
  localparam logic REG_MAX_PPS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_HDR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SPS  = 2'd1,
    KIND_PPS  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [LenW-1:0] max_sps;
    logic [LenW-1:0] max_pps;
  } limits_t;

  typedef struct packed {
    logic [LenW-1:0] pps_size;
    logic [LenW-1:0] sps_size;
    logic [7:0]      hdr_level;
    logic [7:0]      hdr_compat;
    logic [7:0]      hdr_profile;
    status_e         status;
    logic            record_done;
    kind_e           payload_kind;
    logic [7:0]      payload_byte;
  } result_t;

endpackage

FILE: rtl/acrp_cfg.sv
module acrp_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o,
  output acrp_pkg::limits_t limits_o
);
  import acrp_pkg::*;

  logic [LenW-1:0] max_sps_q, max_sps_d;
  logic [LenW-1:0] max_pps_q, max_pps_d;
  logic            wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;

  always_comb begin
    max_sps_d = max_sps_q;
    max_pps_d = max_pps_q;
    prdata_o  = '0;
    unique case (paddr_i[2])
      REG_MAX_SPS: begin
        prdata_o = {16'd0, max_sps_q};
        if (wr_en) max_sps_d = pwdata_i[LenW-1:0];
      end
      REG_MAX_PPS: begin
        prdata_o = {16'd0, max_pps_q};
        if (wr_en) max_pps_d = pwdata_i[LenW-1:0];
      end
      default: prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sps_q <= MAX_SPS_RESET;
      max_pps_q <= MAX_PPS_RESET;
    end else begin
      max_sps_q <= max_sps_d;
      max_pps_q <= max_pps_d;
    end
  end

  assign limits_o.max_sps = max_sps_q;
  assign limits_o.max_pps = max_pps_q;

endmodule

FILE: rtl/acrp_parse.sv
module acrp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  input  acrp_pkg::limits_t limits_i,
  output acrp_pkg::result_t result_o
);
  import acrp_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic              check_q, check_d;
  logic [7:0]        prof_q, prof_d;
  logic [7:0]        compat_q, compat_d;
  logic [7:0]        level_q, level_d;
  logic [LenW-1:0]   sps_len_q, sps_len_d;
  logic [LenW-1:0]   pps_len_q, pps_len_d;

  logic [LenW-1:0]   len;
  logic              done;
  logic              idle;
  status_e           st;
  kind_e             kind;
  logic [7:0]        pbyte;

  assign len = {len_hi_q, data_i};

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    len_hi_d  = len_hi_q;
    check_d   = check_q;
    prof_d    = prof_q;
    compat_d  = compat_q;
    level_d   = level_q;
    sps_len_d = sps_len_q;
    pps_len_d = pps_len_q;
    done      = 1'b0;
    idle      = 1'b0;
    st        = ST_OK;
    kind      = KIND_NONE;
    pbyte     = '0;

    unique case (phase_q)
      PH_VER: begin
        check_d = (data_i == CFG_REC_VERSION);
        phase_d = PH_PROF;
      end
      PH_PROF: begin
        prof_d  = data_i;
        phase_d = PH_COMPAT;
      end
      PH_COMPAT: begin
        compat_d = data_i;
        phase_d  = PH_LEVEL;
      end
      PH_LEVEL: begin
        level_d = data_i;
        phase_d = PH_LENSIZE;
      end
      PH_LENSIZE: begin
        // version result is held in check_q until here
        if (!check_q || ((data_i & LEN_SIZE_MASK) != LEN_SIZE_MASK)) begin
          done = 1'b1;
          st   = ST_BAD_HDR;
        end else begin
          phase_d = PH_SPS_CNT;
        end
      end
      PH_SPS_CNT: begin
        check_d = ((data_i & SPS_CNT_MASK) == PS_COUNT_ONE);
        phase_d = PH_SPS_LH;
      end
      PH_SPS_LH: begin
        len_hi_d = data_i;
        phase_d  = PH_SPS_LL;
      end
      PH_SPS_LL: begin
        sps_len_d = len;
        if (!check_q || (len > limits_i.max_sps)) begin
          done = 1'b1;
          st   = ST_OVERFLOW;
        end else if (len == '0) begin
          phase_d = PH_PPS_CNT;
        end else begin
          left_d  = len;
          phase_d = PH_SPS_DATA;
        end
      end
      PH_SPS_DATA: begin
        kind   = KIND_SPS;
        pbyte  = data_i;
        left_d = left_q - 1'b1;
        if (left_q == LenW'(1)) phase_d = PH_PPS_CNT;
      end
      PH_PPS_CNT: begin
        check_d = (data_i == PS_COUNT_ONE);
        phase_d = PH_PPS_LH;
      end
      PH_PPS_LH: begin
        len_hi_d = data_i;
        phase_d  = PH_PPS_LL;
      end
      PH_PPS_LL: begin
        pps_len_d = len;
        if (!check_q || (len > limits_i.max_pps)) begin
          done = 1'b1;
          st   = ST_OVERFLOW;
        end else if (len == '0) begin
          done = 1'b1;
        end else begin
          left_d  = len;
          phase_d = PH_PPS_DATA;
        end
      end
      PH_PPS_DATA: begin
        kind   = KIND_PPS;
        pbyte  = data_i;
        left_d = left_q - 1'b1;
        if (left_q == LenW'(1)) done = 1'b1;
      end
      default: begin
        // trailing bytes after completion, up to the last flag
        idle = 1'b1;
        if (last_i) phase_d = PH_VER;
      end
    endcase

    if (!idle) begin
      if (!done && last_i) begin
        done = 1'b1;
        st   = ST_TRUNC;
      end
      if (done) phase_d = last_i ? PH_VER : PH_IGNORE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VER;
      left_q    <= '0;
      len_hi_q  <= '0;
      check_q   <= 1'b0;
      prof_q    <= '0;
      compat_q  <= '0;
      level_q   <= '0;
      sps_len_q <= '0;
      pps_len_q <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      len_hi_q  <= len_hi_d;
      check_q   <= check_d;
      prof_q    <= prof_d;
      compat_q  <= compat_d;
      level_q   <= level_d;
      sps_len_q <= sps_len_d;
      pps_len_q <= pps_len_d;
    end
  end

  always_comb begin
    result_o.payload_byte = pbyte;
    result_o.payload_kind = kind;
    result_o.record_done  = done;
    result_o.status       = done ? st : ST_OK;
    result_o.hdr_profile  = prof_d;
    result_o.hdr_compat   = compat_d;
    result_o.hdr_level    = level_d;
    result_o.sps_size     = sps_len_d;
    result_o.pps_size     = pps_len_d;
  end

endmodule

FILE: rtl/avc_config_record_parser_core.sv
// Channel   | Dir | Beat contents
// s_axis    | in  | tdata[7:0] data_byte, tlast last_byte
// m_axis    | out | tdata payload/status/header/lengths, tuser payload_kind, tlast record_done
// apb       | in  | 0x0 max_sps_len, 0x4 max_pps_len (16 bits each)
//
// Every input beat gives exactly one output beat; one beat per cycle unless m_axis stalls.
// The byte is parsed in the cycle it is taken and the result lands in the
// output register on the same edge.
// Stalls on m_axis hold the output register; s_axis tready drops only while
// that register is full and not being taken.
// Reset clears the phase, counters and header fields and sets the limits (256 / 64).
module avc_config_record_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] payload_byte, [9:8] status, [17:10] hdr_profile, [25:18] hdr_compat,
  // [33:26] hdr_level, [49:34] sps_size, [65:50] pps_size, [71:66] zero
  output logic [71:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] payload_kind
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import acrp_pkg::*;

  limits_t limits;
  result_t result;
  result_t out_q;
  logic    out_valid_q, out_valid_d;
  logic    accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  acrp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .limits_o  (limits)
  );

  acrp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .limits_i (limits),
    .result_o (result)
  );

  assign out_valid_d = accept || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= result;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.payload_kind;
  assign m_axis_tlast_o  = out_q.record_done;
  assign m_axis_tdata_o  = {6'd0, out_q.pps_size, out_q.sps_size, out_q.hdr_level,
                            out_q.hdr_compat, out_q.hdr_profile, out_q.status,
                            out_q.payload_byte};

  // an accepted byte always shows up as an output beat next cycle
  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted byte produced no output beat");

  // a nonzero status is only reported on the completing beat
  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_q.status != ST_OK)) |-> out_q.record_done)
    else $error("status without record_done");

  // payload bytes are never tagged with the unused kind code
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("illegal payload kind");

  // no payload passes out on a bad-header or length-overflow completion
  a_hdr_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_q.status == ST_BAD_HDR || out_q.status == ST_OVERFLOW))
      |-> (out_q.payload_kind == KIND_NONE))
    else $error("payload tagged on header or length failure");

endmodule
